### design/yrcm_pkg.sv
`timescale 1ns / 1ps

package yrcm_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // pair counter and row counter widths
   localparam int PAIR_W = $clog2(MAX_WIDTH / 2);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);

   // fixed field widths
   localparam int DIM_W  = 13;
   localparam int OFS_W  = 12;
   localparam int IDX_W  = 24;
   localparam int CMP_W  = 14;
   localparam int CSR_IW = 3;

   localparam logic [CSR_IW-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_CROP_LEFT     = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_CROP_TOP      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DEST_WIDTH    = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_DEST_HEIGHT   = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_REVERSE_ROWS  = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_REVERSE_COLS  = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0] source_width;
      logic [DIM_W-1:0] source_height;
      logic [OFS_W-1:0] crop_left;
      logic [OFS_W-1:0] crop_top;
      logic [DIM_W-1:0] dest_width;
      logic [DIM_W-1:0] dest_height;
      logic             reverse_rows;
      logic             reverse_cols;
   } cfg_type;

   typedef struct packed {
      logic             keep;
      logic             last;
      logic [DIM_W-1:0] dest_row;
      logic [DIM_W-1:0] dest_col;
   } place_type;

endpackage

### design/yrcm_position.sv
`timescale 1ns / 1ps

module yrcm_position
   import yrcm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      step,
   output place_type place
);

   logic [PAIR_W-1:0] pair_column_ff, pair_column_in;
   logic [ROW_W-1:0]  source_row_ff, source_row_in;

   logic [CMP_W-1:0] pairs_lim;
   logic [CMP_W-1:0] rows_lim;
   logic [CMP_W-1:0] col_next;
   logic [CMP_W-1:0] row_next;
   logic [CMP_W-1:0] col;
   logic [CMP_W-1:0] row;
   logic [CMP_W-1:0] left;
   logic [CMP_W-1:0] top;
   logic [CMP_W-1:0] dw;
   logic [CMP_W-1:0] dh;
   logic [CMP_W-1:0] dr;
   logic [CMP_W-1:0] dc;
   logic [CMP_W-1:0] dr_out;
   logic [CMP_W-1:0] dc_out;

   // row length in pairs and frame height, saturated
   always_comb begin
      pairs_lim = CMP_W'(cfg.source_width[DIM_W-1:1]);
      if (pairs_lim == '0) begin
         pairs_lim = CMP_W'(1);
      end else if (pairs_lim > CMP_W'(MAX_WIDTH / 2)) begin
         pairs_lim = CMP_W'(MAX_WIDTH / 2);
      end
      rows_lim = CMP_W'(cfg.source_height);
      if (rows_lim == '0) begin
         rows_lim = CMP_W'(1);
      end else if (rows_lim > CMP_W'(MAX_HEIGHT)) begin
         rows_lim = CMP_W'(MAX_HEIGHT);
      end
   end

   always_comb begin
      col_next       = CMP_W'(pair_column_ff) + CMP_W'(1);
      row_next       = CMP_W'(source_row_ff) + CMP_W'(1);
      pair_column_in = pair_column_ff;
      source_row_in  = source_row_ff;
      if (step) begin
         if (col_next >= pairs_lim) begin
            pair_column_in = '0;
            if (row_next >= rows_lim) begin
               source_row_in = '0;
            end else begin
               source_row_in = row_next[ROW_W-1:0];
            end
         end else begin
            pair_column_in = col_next[PAIR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_column_ff <= '0;
         source_row_ff  <= '0;
      end else begin
         pair_column_ff <= pair_column_in;
         source_row_ff  <= source_row_in;
      end
   end

   // crop window test and destination position
   always_comb begin
      col    = CMP_W'({pair_column_ff, 1'b0});
      row    = CMP_W'(source_row_ff);
      left   = CMP_W'({cfg.crop_left[OFS_W-1:1], 1'b0});
      top    = CMP_W'(cfg.crop_top);
      dw     = CMP_W'({cfg.dest_width[DIM_W-1:1], 1'b0});
      dh     = CMP_W'(cfg.dest_height);
      dr     = row - top;
      dc     = col - left;
      dr_out = cfg.reverse_rows ? (dh - CMP_W'(1) - dr) : dr;
      dc_out = cfg.reverse_cols ? (dw - CMP_W'(1) - dc) : dc;

      place.keep     = (dw != '0) && (dh != '0) && (row >= top) && (dr < dh)
                       && (col >= left) && (dc < dw);
      place.last     = (dr == dh - CMP_W'(1)) && (dc == dw - CMP_W'(2));
      place.dest_row = dr_out[DIM_W-1:0];
      place.dest_col = dc_out[DIM_W-1:0];
   end

endmodule

### design/yrcm_pixel.sv
`timescale 1ns / 1ps

module yrcm_pixel
   import yrcm_pkg::*;
(
   input  logic [7:0] luma,
   input  logic [7:0] chroma_u,
   input  logic [7:0] chroma_v,
   output logic [7:0] red,
   output logic [7:0] green,
   output logic [7:0] blue
);

   logic signed [21:0] y_ofs;
   logic signed [21:0] d;
   logic signed [21:0] e;
   logic signed [21:0] c;
   logic signed [21:0] r_sum;
   logic signed [21:0] g_sum;
   logic signed [21:0] b_sum;

   // negative to zero, otherwise scale down by 1024 and saturate
   function automatic logic [7:0] clamp_channel(input logic signed [21:0] s);
      logic [7:0] res;
      if (s[21]) begin
         res = 8'd0;
      end else if (|s[20:18]) begin
         res = 8'd255;
      end else begin
         res = s[17:10];
      end
      return res;
   endfunction

   always_comb begin
      y_ofs = $signed({14'd0, luma}) - 22'sd16;
      d     = $signed({14'd0, chroma_u}) - 22'sd128;
      e     = $signed({14'd0, chroma_v}) - 22'sd128;
      c     = y_ofs * 22'sd1192;
      r_sum = c + e * 22'sd1634;
      g_sum = c - e * 22'sd832 - d * 22'sd400;
      b_sum = c + d * 22'sd2066;
      red   = clamp_channel(r_sum);
      green = clamp_channel(g_sum);
      blue  = clamp_channel(b_sum);
   end

endmodule

### design/yuv420_to_rgb_crop_mirror.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_tvalid/tready    tdata: luma_even, luma_odd, chroma_u, chroma_v
// rsp       out        rsp_tvalid/tready    tdata: dest_index, rgb even/odd, gray; tlast: frame_done
// csr       in         csr_wen              csr_index, csr_wdata
//
// one pair accepted per clock unless rsp stalls; two register stages, rsp_tvalid is registered
// behind both (crop test and position into the input register, index multiply and
// colour conversion into the output register). pairs outside the crop window leave no item.
// synchronous reset restores register defaults and clears the row and column counters.
// a stall on rsp holds both stages; req_tready drops only when both are full.

module yuv420_to_rgb_crop_mirror
   import yrcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // luma_even, luma_odd, chroma_u, chroma_v
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [87:0]       rsp_tdata,   // dest_index, red_even, green_even, blue_even,
                                          // red_odd, green_odd, blue_odd, gray_even, gray_odd
   output logic              rsp_tlast,   // frame_done
   input  logic              csr_wen,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [DIM_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   place_type place;

   logic        s1_valid_ff, s1_valid_in;
   place_type   s1_place_ff;
   logic [31:0] s1_pixels_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [87:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic accept;
   logic s2_load;

   logic [2*DIM_W-1:0] row_base;
   logic [IDX_W-1:0]   dest_index;
   logic [7:0]         red_even, green_even, blue_even;
   logic [7:0]         red_odd, green_odd, blue_odd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  cfg_in.source_width  = csr_wdata;
            CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_wdata;
            CSR_CROP_LEFT:     cfg_in.crop_left     = csr_wdata[OFS_W-1:0];
            CSR_CROP_TOP:      cfg_in.crop_top      = csr_wdata[OFS_W-1:0];
            CSR_DEST_WIDTH:    cfg_in.dest_width    = csr_wdata;
            CSR_DEST_HEIGHT:   cfg_in.dest_height   = csr_wdata;
            CSR_REVERSE_ROWS:  cfg_in.reverse_rows  = csr_wdata[0];
            CSR_REVERSE_COLS:  cfg_in.reverse_cols  = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= DIM_W'(640);
         cfg_ff.source_height <= DIM_W'(480);
         cfg_ff.crop_left     <= '0;
         cfg_ff.crop_top      <= '0;
         cfg_ff.dest_width    <= DIM_W'(640);
         cfg_ff.dest_height   <= DIM_W'(480);
         cfg_ff.reverse_rows  <= 1'b0;
         cfg_ff.reverse_cols  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign accept     = req_tvalid && req_tready;

   yrcm_position u_position (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (accept),
      .place (place)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = place.keep;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s2_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_place_ff  <= place;
         s1_pixels_ff <= req_tdata;
      end
   end

   // index wraps to its 24 bits
   always_comb begin
      row_base   = s1_place_ff.dest_row * {cfg_ff.dest_width[DIM_W-1:1], 1'b0};
      dest_index = row_base[IDX_W-1:0] + IDX_W'(s1_place_ff.dest_col);
   end

   yrcm_pixel u_pixel_even (
      .luma     (s1_pixels_ff[7:0]),
      .chroma_u (s1_pixels_ff[23:16]),
      .chroma_v (s1_pixels_ff[31:24]),
      .red      (red_even),
      .green    (green_even),
      .blue     (blue_even)
   );

   yrcm_pixel u_pixel_odd (
      .luma     (s1_pixels_ff[15:8]),
      .chroma_u (s1_pixels_ff[23:16]),
      .chroma_v (s1_pixels_ff[31:24]),
      .red      (red_odd),
      .green    (green_odd),
      .blue     (blue_odd)
   );

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_data_ff <= {s1_pixels_ff[15:8], s1_pixels_ff[7:0],
                         blue_odd, green_odd, red_odd,
                         blue_even, green_even, red_even,
                         dest_index};
         rsp_last_ff <= s1_place_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
